@@ sv/deq_pkg.sv @@
`timescale 1ns / 1ps

package deq_pkg;

    localparam int DEPTH  = 64;
    localparam int IDX_W  = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int WORD_W = 32;
    localparam int OCC_W  = 7;

    typedef enum logic [1:0] {
        REQ_PUSH_BACK  = 2'd0,
        REQ_PUSH_FRONT = 2'd1,
        REQ_POP_FRONT  = 2'd2,
        REQ_POP_BACK   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE,
        S_FETCH
    } t_state;

    typedef struct packed {
        t_req                     req_type;
        logic signed [WORD_W-1:0] push_value;
    } t_in_word;

    typedef struct packed {
        logic signed [WORD_W-1:0] popped_value;
        t_status                  status;
        logic signed [WORD_W-1:0] front_value;
        logic signed [WORD_W-1:0] back_value;
        logic                     is_empty;
        logic [OCC_W-1:0]         occupancy;
    } t_out_word;

    typedef struct packed {
        logic              we;
        logic [IDX_W-1:0]  waddr;
        logic [WORD_W-1:0] wdata;
        logic              re;
        logic [IDX_W-1:0]  raddr;
    } t_ram_req;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] i);
        return (i == IDX_W'(DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [IDX_W-1:0] idx_dec(input logic [IDX_W-1:0] i);
        return (i == '0) ? IDX_W'(DEPTH - 1) : i - 1'b1;
    endfunction

endpackage

@@ sv/deq_ram.sv @@
`timescale 1ns / 1ps

module deq_ram (
    input  logic                           i_clk,
    input  deq_pkg::t_ram_req              i_req,
    output logic [deq_pkg::WORD_W-1:0]     o_rdata
);
    import deq_pkg::*;

    logic [WORD_W-1:0] r_mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.waddr] <= i_req.wdata;
        end
    end

    // read data holds while re is low
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rdata <= r_mem[i_req.raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/deq_ctrl.sv @@
`timescale 1ns / 1ps

module deq_ctrl (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  deq_pkg::t_in_word           i_in_word,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output deq_pkg::t_out_word          o_out_word,
    output deq_pkg::t_ram_req           o_ram_req,
    input  logic [deq_pkg::WORD_W-1:0]  i_ram_rdata
);
    import deq_pkg::*;

    t_state            r_state, n_state;
    logic [IDX_W-1:0]  r_head, n_head;
    logic [IDX_W-1:0]  r_tail, n_tail;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    // cached end words; the memory is read only to refill an end after a pop
    logic [WORD_W-1:0] r_front, n_front;
    logic [WORD_W-1:0] r_back, n_back;
    logic [WORD_W-1:0] r_pop, n_pop;
    t_status           r_status, n_status;
    logic              r_upd_front, n_upd_front;
    logic              r_upd_back, n_upd_back;
    logic              r_out_valid;
    t_out_word         r_out_word;

    logic              w_acc;
    logic              w_full;
    logic              w_empty;
    logic              w_load;
    logic [WORD_W-1:0] w_front;
    logic [WORD_W-1:0] w_back;
    t_ram_req          w_ram;

    assign w_full  = (r_cnt == CNT_W'(DEPTH));
    assign w_empty = (r_cnt == '0);
    assign w_acc   = i_in_valid && o_in_ready;
    assign w_load  = (r_state == S_FETCH) && (!r_out_valid || i_out_ready);
    assign w_front = r_upd_front ? i_ram_rdata : r_front;
    assign w_back  = r_upd_back ? i_ram_rdata : r_back;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE:  if (w_acc) n_state = S_FETCH;
            S_FETCH: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the state machine
    always_comb begin
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_FETCH: o_in_ready = 1'b0;
            default: o_in_ready = 1'b0;
        endcase
    end

    // request decode: pointer update, memory write or end refill read
    always_comb begin
        n_head      = r_head;
        n_tail      = r_tail;
        n_cnt       = r_cnt;
        n_front     = r_front;
        n_back      = r_back;
        n_pop       = r_pop;
        n_status    = r_status;
        n_upd_front = r_upd_front;
        n_upd_back  = r_upd_back;
        w_ram       = '{we: 1'b0, waddr: r_tail, wdata: i_in_word.push_value,
                        re: 1'b0, raddr: r_head};
        if (w_acc) begin
            n_pop       = '0;
            n_status    = ST_OK;
            n_upd_front = 1'b0;
            n_upd_back  = 1'b0;
            case (i_in_word.req_type)
                REQ_PUSH_BACK: begin
                    if (w_full) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        w_ram.we    = 1'b1;
                        w_ram.waddr = r_tail;
                        n_tail      = idx_inc(r_tail);
                        n_cnt       = r_cnt + 1'b1;
                        n_back      = i_in_word.push_value;
                        if (w_empty) n_front = i_in_word.push_value;
                    end
                end
                REQ_PUSH_FRONT: begin
                    if (w_full) begin
                        n_status = ST_OVERFLOW;
                    end else begin
                        w_ram.we    = 1'b1;
                        w_ram.waddr = idx_dec(r_head);
                        n_head      = idx_dec(r_head);
                        n_cnt       = r_cnt + 1'b1;
                        n_front     = i_in_word.push_value;
                        if (w_empty) n_back = i_in_word.push_value;
                    end
                end
                REQ_POP_FRONT: begin
                    if (w_empty) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        n_pop       = r_front;
                        n_head      = idx_inc(r_head);
                        n_cnt       = r_cnt - 1'b1;
                        w_ram.re    = 1'b1;
                        w_ram.raddr = idx_inc(r_head);
                        n_upd_front = 1'b1;
                    end
                end
                REQ_POP_BACK: begin
                    if (w_empty) begin
                        n_status = ST_UNDERFLOW;
                    end else begin
                        n_pop       = r_back;
                        n_tail      = idx_dec(r_tail);
                        n_cnt       = r_cnt - 1'b1;
                        w_ram.re    = 1'b1;
                        w_ram.raddr = idx_dec(idx_dec(r_tail));
                        n_upd_back  = 1'b1;
                    end
                end
                default: n_status = ST_OK;
            endcase
        end else if (w_load) begin
            n_front = w_front;
            n_back  = w_back;
        end
    end

    assign o_ram_req = w_ram;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_head  <= '0;
            r_tail  <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_head  <= n_head;
            r_tail  <= n_tail;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_front     <= n_front;
        r_back      <= n_back;
        r_pop       <= n_pop;
        r_status    <= n_status;
        r_upd_front <= n_upd_front;
        r_upd_back  <= n_upd_back;
    end

    // output word register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_out_word.popped_value <= r_pop;
            r_out_word.status       <= r_status;
            r_out_word.front_value  <= w_empty ? '0 : w_front;
            r_out_word.back_value   <= w_empty ? '0 : w_back;
            r_out_word.is_empty     <= w_empty;
            r_out_word.occupancy    <= OCC_W'(r_cnt);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    // ring consistency: head plus count lands on tail
    logic [CNT_W:0] w_chk_sum;
    logic [CNT_W:0] w_chk_tail;
    assign w_chk_sum  = (CNT_W + 1)'(r_head) + (CNT_W + 1)'(r_cnt);
    assign w_chk_tail = (w_chk_sum >= (CNT_W + 1)'(DEPTH))
                        ? w_chk_sum - (CNT_W + 1)'(DEPTH) : w_chk_sum;

    a_ring_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chk_tail == (CNT_W + 1)'(r_tail))
        else $error("head, tail and count disagree");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(DEPTH))
        else $error("count beyond depth");

    a_pop_decrements: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_acc && !w_empty && (i_in_word.req_type == REQ_POP_FRONT ||
                              i_in_word.req_type == REQ_POP_BACK)
        |=> r_cnt == $past(r_cnt) - 1'b1)
        else $error("pop did not decrement count");

    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_word.status == ST_OVERFLOW
        |-> r_out_word.occupancy == OCC_W'(DEPTH))
        else $error("overflow reported while not full");

    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_word.status == ST_UNDERFLOW |-> r_out_word.is_empty)
        else $error("underflow reported while not empty");

endmodule

@@ sv/double_ended_queue_top.sv @@
`timescale 1ns / 1ps

// Double-ended queue of 64 signed 32-bit words kept in a ring buffer. Each
// input word is a request (push back, push front, pop front, pop back) and
// yields exactly one output word: the popped value, a status (ok, overflow,
// underflow), the front and back words after the request (zero when empty),
// an empty flag and the occupancy. An accepted request goes to a fetch state,
// which loads the result into the output register once the output is free;
// only then is a new request taken. The fetch uses the registered read of the
// single storage memory, which refills the front or back word after a pop.
// Front and back words are also in registers, so pushes never read memory.
// Storage needs no clearing after reset; an empty slot's word is never output.
module double_ended_queue_top (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  deq_pkg::t_in_word   i_in_word,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output deq_pkg::t_out_word  o_out_word
);
    import deq_pkg::*;

    t_ram_req          w_ram_req;
    logic [WORD_W-1:0] w_ram_rdata;

    deq_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word),
        .o_ram_req   (w_ram_req),
        .i_ram_rdata (w_ram_rdata)
    );

    deq_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_ram_req),
        .o_rdata (w_ram_rdata)
    );

endmodule

@@ tb/double_ended_queue_top_tb.sv @@
`timescale 1ns / 1ps

module double_ended_queue_top_tb;
    import deq_pkg::*;

    localparam int CLK_HALF   = 4;
    localparam int IDLE_LIMIT = 3000;
    localparam int LONG_HOLD  = 400;

    typedef enum logic {
        RX_ALWAYS,
        RX_PATTERN
    } t_rx_mode;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    logic       i_out_ready = 1'b0;
    t_in_word   i_in_word   = '0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_out_word  o_out_word;

    // deque state as predicted
    logic signed [WORD_W-1:0] model_slots [DEPTH];
    logic [IDX_W-1:0]         model_head = '0;
    logic [IDX_W-1:0]         model_tail = '0;
    logic [CNT_W-1:0]         model_fill = '0;

    t_out_word expected_words [$];
    int        error_count = 0;
    int        idle_cycles = 0;
    int        burst_left  = 0;
    bit        tx_gaps     = 1'b0;
    t_rx_mode  rx_mode     = RX_ALWAYS;
    int        stall_req_count = 0;
    int        stall_ack_count = 0;
    int        hold_left   = 0;
    int        rx_phase    = 0;

    double_ended_queue_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_word  (o_out_word)
    );

    always #CLK_HALF i_clk = ~i_clk;

    function automatic t_out_word deque_apply(input t_in_word w);
        t_out_word r;
        r        = '0;
        r.status = ST_OK;
        case (w.req_type)
            REQ_PUSH_BACK: begin
                if (model_fill == CNT_W'(DEPTH)) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    model_slots[model_tail] = w.push_value;
                    model_tail = model_tail + 1'b1;
                    model_fill = model_fill + 1'b1;
                end
            end
            REQ_PUSH_FRONT: begin
                if (model_fill == CNT_W'(DEPTH)) begin
                    r.status = ST_OVERFLOW;
                end else begin
                    model_head = model_head - 1'b1;
                    model_slots[model_head] = w.push_value;
                    model_fill = model_fill + 1'b1;
                end
            end
            REQ_POP_FRONT: begin
                if (model_fill == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    r.popped_value = model_slots[model_head];
                    model_head = model_head + 1'b1;
                    model_fill = model_fill - 1'b1;
                end
            end
            default: begin
                if (model_fill == 0) begin
                    r.status = ST_UNDERFLOW;
                end else begin
                    model_tail = model_tail - 1'b1;
                    r.popped_value = model_slots[model_tail];
                    model_fill = model_fill - 1'b1;
                end
            end
        endcase
        if (model_fill != 0) begin
            r.front_value = model_slots[model_head];
            r.back_value  = model_slots[model_tail - 1'b1];
        end
        r.is_empty  = (model_fill == 0);
        r.occupancy = OCC_W'(model_fill);
        return r;
    endfunction

    // mostly full-range random, with the corner words mixed in
    function automatic logic [WORD_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return 32'hFFFF_FFFF;
            3:       return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(input t_req req, input logic [WORD_W-1:0] value);
        int       gap;
        t_in_word w;
        w.req_type   = req;
        w.push_value = value;
        if (tx_gaps) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap        = $urandom_range(0, 12);
                if (gap > 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
            burst_left--;
        end
        i_in_valid <= 1'b1;
        i_in_word  <= w;
        do @(posedge i_clk); while (!o_in_ready);
        expected_words.push_back(deque_apply(w));
    endtask

    task automatic compare_field(input string name, input logic [WORD_W-1:0] exp_v,
                                 input logic [WORD_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s mismatch: expected %0h, actual %0h", name, exp_v, act_v);
            error_count++;
        end
    endtask

    // output side: check each accepted word, then pick the next ready value
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected output word %0h", o_out_word);
                error_count++;
            end else begin
                t_out_word e;
                e = expected_words.pop_front();
                compare_field("popped_value", e.popped_value, o_out_word.popped_value);
                compare_field("status", WORD_W'(e.status), WORD_W'(o_out_word.status));
                compare_field("front_value", e.front_value, o_out_word.front_value);
                compare_field("back_value", e.back_value, o_out_word.back_value);
                compare_field("is_empty", WORD_W'(e.is_empty),
                              WORD_W'(o_out_word.is_empty));
                compare_field("occupancy", WORD_W'(e.occupancy),
                              WORD_W'(o_out_word.occupancy));
            end
        end
        if (stall_ack_count != stall_req_count) begin
            hold_left       = LONG_HOLD;
            stall_ack_count = stall_req_count;
        end
        rx_phase = (rx_phase + 1) % 23;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (rx_mode == RX_ALWAYS) begin
            i_out_ready <= 1'b1;
        end else begin
            // fixed stretch of stalls each period, random drops elsewhere
            i_out_ready <= (rx_phase >= 5) && ($urandom_range(0, 3) != 0);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("** double_ended_queue_top: FAILED **");
                $finish;
            end
        end
    end

    task automatic test_directed_edges();
        tx_gaps = 1'b0;
        rx_mode = RX_ALWAYS;
        send_request(REQ_POP_FRONT, 32'h1234_5678);
        send_request(REQ_POP_BACK, 32'hFFFF_FFFF);
        send_request(REQ_PUSH_BACK, 32'h7FFF_FFFF);
        send_request(REQ_PUSH_FRONT, 32'h8000_0000);
        send_request(REQ_PUSH_BACK, 32'h0000_0000);
        send_request(REQ_PUSH_FRONT, 32'hFFFF_FFFF);
        send_request(REQ_PUSH_BACK, 32'h5555_5555);
        send_request(REQ_PUSH_FRONT, 32'hAAAA_AAAA);
        send_request(REQ_POP_FRONT, 32'h0);
        send_request(REQ_POP_BACK, 32'h0);
        send_request(REQ_POP_FRONT, 32'h0);
        send_request(REQ_POP_BACK, 32'h0);
        send_request(REQ_POP_FRONT, 32'h0);
        send_request(REQ_POP_BACK, 32'h0);
        send_request(REQ_POP_FRONT, 32'h0);
        send_request(REQ_PUSH_FRONT, 32'h0000_0001);
        send_request(REQ_POP_BACK, 32'h0);
        send_request(REQ_PUSH_BACK, 32'h0000_0002);
        send_request(REQ_POP_FRONT, 32'h0);
    endtask

    task automatic test_fill_and_drain();
        tx_gaps = 1'b1;
        rx_mode = RX_PATTERN;
        repeat (DEPTH) begin
            send_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK, pick_value());
        end
        send_request(REQ_PUSH_BACK, pick_value());
        send_request(REQ_PUSH_FRONT, pick_value());
        repeat (DEPTH) begin
            send_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK, pick_value());
        end
        send_request(REQ_POP_FRONT, pick_value());
        send_request(REQ_POP_BACK, pick_value());
    endtask

    // low occupancy; the pointers step 40 slots one way, then 40 slots back
    task automatic test_pointer_wrap();
        tx_gaps = 1'b0;
        rx_mode = RX_ALWAYS;
        repeat (40) begin
            send_request(REQ_PUSH_BACK, pick_value());
            send_request(REQ_POP_FRONT, pick_value());
        end
        repeat (40) begin
            send_request(REQ_PUSH_FRONT, pick_value());
            send_request(REQ_POP_BACK, pick_value());
        end
    endtask

    // receiver holds off while requests keep coming, input must stall
    task automatic test_output_hold();
        tx_gaps = 1'b0;
        rx_mode = RX_PATTERN;
        stall_req_count++;
        repeat (100) begin
            send_request(t_req'($urandom_range(0, 3)), pick_value());
        end
    endtask

    task automatic test_random_walk();
        bit filling;
        bit push;
        filling = 1'b1;
        for (int n = 0; n < 700; n++) begin
            tx_gaps = (n % 200) < 150;
            rx_mode = ((n % 300) < 220) ? RX_PATTERN : RX_ALWAYS;
            if (model_fill == CNT_W'(DEPTH) && $urandom_range(0, 3) == 0) filling = 1'b0;
            if (model_fill == 0 && $urandom_range(0, 3) == 0) filling = 1'b1;
            push = filling ? ($urandom_range(0, 3) != 0) : ($urandom_range(0, 3) == 0);
            if (push) begin
                send_request($urandom_range(0, 1) ? REQ_PUSH_FRONT : REQ_PUSH_BACK,
                             pick_value());
            end else begin
                send_request($urandom_range(0, 1) ? REQ_POP_FRONT : REQ_POP_BACK,
                             pick_value());
            end
        end
    endtask

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_edges();
        test_fill_and_drain();
        test_pointer_wrap();
        test_output_hold();
        test_random_walk();
        i_in_valid <= 1'b0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);
        if (error_count == 0) begin
            $display("** double_ended_queue_top: PASSED **");
        end else begin
            $display("** double_ended_queue_top: FAILED **");
        end
        $finish;
    end

endmodule
